/* sv/bcalt_pkg.sv */
`timescale 1ns / 1ps

package bcalt_pkg;

    localparam int ACC_W      = 72;   // serial accumulator width
    localparam int MPL_W      = 26;   // multiplier shift register width
    localparam int NB_W       = 5;    // multiplier bit count width
    localparam int DIV_W      = 32;   // divider quotient width
    localparam int DIV_CNT_W  = 6;
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 48;
    localparam int RAW_W      = 24;
    localparam int TEMP_W     = 16;
    localparam int PRESS_W    = 24;
    localparam int ALT_W      = 24;

    localparam logic [CFG_IDX_W-1:0] CFG_TEMP   = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_PLOW   = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_PMID   = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_PHIGH  = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_SCALE  = 3'd4;
    localparam logic [CFG_IDX_W-1:0] CFG_SLOPE  = 3'd5;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_ISSUE,
        ST_RUN,
        ST_DIV
    } t_state;

    typedef enum logic [4:0] {
        OP_DD, OP_T3, OP_T2, OP_TS2, OP_TS3,
        OP_A6, OP_A7, OP_A8, OP_B2, OP_B3, OP_B4, OP_BU,
        OP_U2, OP_C, OP_CU, OP_U3, OP_DU, OP_PR,
        OP_K, OP_K1000, OP_ALT
    } t_op;

    typedef struct packed {
        logic                    start;
        logic                    load;
        logic signed [ACC_W-1:0] init;
        logic signed [ACC_W-1:0] mcand;
        logic signed [MPL_W-1:0] mpl;
        logic [NB_W-1:0]         nb;
    } t_mac_cmd;

    typedef struct packed {
        logic             start;
        logic [DIV_W-1:0] rem;
        logic [DIV_W-1:0] lo;
        logic [DIV_W-1:0] divisor;
    } t_div_cmd;

endpackage

/* sv/bcalt_in_if.sv */
`timescale 1ns / 1ps

interface bcalt_in_if;
    import bcalt_pkg::*;

    logic             valid;
    logic             ready;
    logic [RAW_W-1:0] raw_pressure;
    logic [RAW_W-1:0] raw_temperature;
    logic             restart_ground;

    modport source (output valid, output raw_pressure, output raw_temperature,
                    output restart_ground, input ready);
    modport sink (input valid, input raw_pressure, input raw_temperature,
                  input restart_ground, output ready);
endinterface

/* sv/bcalt_out_if.sv */
`timescale 1ns / 1ps

interface bcalt_out_if;
    import bcalt_pkg::*;

    logic                      valid;
    logic                      ready;
    logic signed [TEMP_W-1:0]  temperature;
    logic [PRESS_W-1:0]        pressure;
    logic signed [ALT_W-1:0]   altitude;
    logic                      ground_captured;

    modport source (output valid, output temperature, output pressure,
                    output altitude, output ground_captured, input ready);
    modport sink (input valid, input temperature, input pressure,
                  input altitude, input ground_captured, output ready);
endinterface

/* sv/baro_compensate_altitude.sv */
`timescale 1ns / 1ps

// Channel    Dir  Handshake      Payload
// i_sample   in   valid/ready    raw_pressure, raw_temperature, restart_ground
// o_result   out  valid/ready    temperature, pressure, altitude, ground_captured
// i_cfg_*    in   write enable   register index, write data
//
// One sample at a time through a bit-serial multiply-accumulate unit; a
// sample that captures ground can also run a restoring divider. Synchronous
// active-low reset clears the sequencer and the ground reference. A result
// waits in the output register while the next sample is taken; the sequencer
// holds its last step while that register is full.
module baro_compensate_altitude (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    bcalt_in_if.sink                            i_sample,
    bcalt_out_if.source                         o_result,
    input  logic                                i_cfg_we,
    input  logic [bcalt_pkg::CFG_IDX_W-1:0]     i_cfg_idx,
    input  logic [bcalt_pkg::CFG_DATA_W-1:0]    i_cfg_data
);
    import bcalt_pkg::*;

    localparam logic signed [18:0]      KELVIN_256 = 19'sd69926;
    localparam logic signed [ACC_W-1:0] RND_TS  = ACC_W'(64'sd549755813888);
    localparam logic signed [ACC_W-1:0] RND_PR  = ACC_W'(64'sd33554432);
    localparam logic signed [ACC_W-1:0] RND_ALT = ACC_W'(64'sd32768);

    // configuration registers
    logic [39:0] r_temp_coeffs;
    logic [47:0] r_plow;
    logic [47:0] r_pmid;
    logic [31:0] r_phigh;
    logic [23:0] r_scale;
    logic [31:0] r_slope;

    // sequencer and working registers
    t_state                  r_state, n_state;
    t_op                     r_op, n_op;
    logic [RAW_W-1:0]        r_up, n_up;
    logic signed [25:0]      r_d, n_d;
    logic signed [51:0]      r_x, n_x;
    logic signed [15:0]      r_ts, n_ts;
    logic signed [31:0]      r_ts2, n_ts2;
    logic signed [47:0]      r_ts3, n_ts3;
    logic signed [47:0]      r_p, n_p;
    logic [37:0]             r_u, n_u;
    logic signed [24:0]      r_c, n_c;
    logic [PRESS_W-1:0]      r_pr, n_pr;
    logic [PRESS_W-1:0]      r_gp, n_gp;
    logic [31:0]             r_fac, n_fac;
    logic                    r_cap, n_cap;
    logic                    r_gv, n_gv;

    // output register
    logic                     r_ov, n_ov;
    logic signed [TEMP_W-1:0] r_o_temp, n_o_temp;
    logic [PRESS_W-1:0]       r_o_pr, n_o_pr;
    logic signed [ALT_W-1:0]  r_o_alt, n_o_alt;
    logic                     r_o_cap, n_o_cap;

    t_mac_cmd                w_mac_cmd;
    t_div_cmd                w_div_cmd;
    logic                    w_mac_busy;
    logic signed [ACC_W-1:0] w_acc;
    logic                    w_div_busy;
    logic [DIV_W-1:0]        w_quot;

    // calibration fields
    logic [15:0]        w_t1, w_t2, w_p5, w_p6;
    logic signed [7:0]  w_t3, w_p3, w_p4, w_p7, w_p8, w_p10, w_p11;
    logic signed [15:0] w_p1, w_p2, w_p9;
    logic signed [17:0] w_p1m, w_p2m;

    logic                    w_in_xfer;
    logic                    w_out_free;
    logic signed [ACC_W-1:0] w_tsh, w_psh, w_ash;
    logic signed [15:0]      w_ts_sat;
    logic [PRESS_W-1:0]      w_pr_sat;
    logic signed [ALT_W-1:0] w_alt_sat;
    logic signed [18:0]      w_kel;
    logic signed [25:0]      w_diff;
    logic signed [25:0]      w_d_new;
    logic [DIV_W-1:0]        w_den;

    assign w_t1  = r_temp_coeffs[15:0];
    assign w_t2  = r_temp_coeffs[31:16];
    assign w_t3  = r_temp_coeffs[39:32];
    assign w_p1  = r_plow[15:0];
    assign w_p2  = r_plow[31:16];
    assign w_p3  = r_plow[39:32];
    assign w_p4  = r_plow[47:40];
    assign w_p5  = r_pmid[15:0];
    assign w_p6  = r_pmid[31:16];
    assign w_p7  = r_pmid[39:32];
    assign w_p8  = r_pmid[47:40];
    assign w_p9  = r_phigh[15:0];
    assign w_p10 = r_phigh[23:16];
    assign w_p11 = r_phigh[31:24];
    assign w_p1m = 18'(w_p1) - 18'sd16384;
    assign w_p2m = 18'(w_p2) - 18'sd16384;

    assign w_in_xfer  = i_sample.valid & i_sample.ready;
    assign w_out_free = !r_ov | o_result.ready;
    assign w_d_new    = $signed({2'b00, i_sample.raw_temperature})
                      - $signed({2'b00, w_t1, 8'h00});

    // rounding, scaling and saturation of the finished accumulator
    assign w_tsh = (w_acc + RND_TS) >>> 40;
    assign w_psh = (w_acc + RND_PR) >>> 26;
    assign w_ash = (w_acc + RND_ALT) >>> 16;
    assign w_ts_sat = (w_tsh > ACC_W'(64'sd32767))  ? 16'sh7fff :
                      (w_tsh < ACC_W'(-64'sd32768)) ? 16'sh8000 : w_tsh[15:0];
    assign w_pr_sat = (w_psh < ACC_W'(64'sd0))        ? '0 :
                      (w_psh > ACC_W'(64'sd16777215)) ? '1 : w_psh[23:0];
    assign w_alt_sat = (w_ash > ACC_W'(64'sd8388607))  ? 24'sh7fffff :
                       (w_ash < ACC_W'(-64'sd8388608)) ? 24'sh800000 : w_ash[23:0];

    assign w_kel  = 19'(r_ts) + KELVIN_256;
    assign w_diff = $signed({2'b00, r_gp}) - $signed({2'b00, r_pr});
    assign w_den  = {r_pr, 8'h00};

    // refuse transfers while reset is held
    assign i_sample.ready = (r_state == ST_IDLE) & i_rst_n;

    always_comb begin
        n_state  = r_state;
        n_op     = r_op;
        n_up     = r_up;
        n_d      = r_d;
        n_x      = r_x;
        n_ts     = r_ts;
        n_ts2    = r_ts2;
        n_ts3    = r_ts3;
        n_p      = r_p;
        n_u      = r_u;
        n_c      = r_c;
        n_pr     = r_pr;
        n_gp     = r_gp;
        n_fac    = r_fac;
        n_cap    = r_cap;
        n_gv     = r_gv;
        n_ov     = r_ov & !o_result.ready;
        n_o_temp = r_o_temp;
        n_o_pr   = r_o_pr;
        n_o_alt  = r_o_alt;
        n_o_cap  = r_o_cap;

        w_mac_cmd       = '0;
        w_div_cmd       = '0;
        w_div_cmd.rem   = w_acc[63:32];
        w_div_cmd.lo    = w_acc[31:0];
        w_div_cmd.divisor = w_den;

        case (r_state)
            ST_IDLE: begin
                if (w_in_xfer) begin
                    // restart drops the reference, so this sample captures ground
                    n_up    = i_sample.raw_pressure;
                    n_d     = w_d_new;
                    n_cap   = i_sample.restart_ground | !r_gv;
                    n_gv    = 1'b1;
                    n_op    = OP_DD;
                    n_state = ST_ISSUE;
                end
            end

            ST_ISSUE: begin
                // load the serial unit with this step's operands
                w_mac_cmd.start = 1'b1;
                w_mac_cmd.load  = 1'b1;
                case (r_op)
                    OP_DD: begin
                        w_mac_cmd.mcand = ACC_W'(r_d);
                        w_mac_cmd.mpl   = r_d;
                        w_mac_cmd.nb    = NB_W'(26);
                    end
                    OP_T3: begin
                        w_mac_cmd.mcand = ACC_W'(r_x);
                        w_mac_cmd.mpl   = MPL_W'(w_t3);
                        w_mac_cmd.nb    = NB_W'(8);
                    end
                    OP_T2: begin
                        w_mac_cmd.load  = 1'b0;
                        w_mac_cmd.mcand = ACC_W'(r_d) <<< 18;
                        w_mac_cmd.mpl   = MPL_W'(w_t2);
                        w_mac_cmd.nb    = NB_W'(17);
                    end
                    OP_TS2: begin
                        w_mac_cmd.mcand = ACC_W'(r_ts);
                        w_mac_cmd.mpl   = MPL_W'(r_ts);
                        w_mac_cmd.nb    = NB_W'(16);
                    end
                    OP_TS3: begin
                        w_mac_cmd.mcand = ACC_W'(r_ts2);
                        w_mac_cmd.mpl   = MPL_W'(r_ts);
                        w_mac_cmd.nb    = NB_W'(16);
                    end
                    OP_A6: begin
                        w_mac_cmd.init  = ACC_W'(w_p5) <<< 42;
                        w_mac_cmd.mcand = ACC_W'(r_ts) <<< 25;
                        w_mac_cmd.mpl   = MPL_W'(w_p6);
                        w_mac_cmd.nb    = NB_W'(17);
                    end
                    OP_A7: begin
                        w_mac_cmd.load  = 1'b0;
                        w_mac_cmd.mcand = ACC_W'(r_ts2) <<< 15;
                        w_mac_cmd.mpl   = MPL_W'(w_p7);
                        w_mac_cmd.nb    = NB_W'(8);
                    end
                    OP_A8: begin
                        w_mac_cmd.load  = 1'b0;
                        w_mac_cmd.mcand = ACC_W'(r_ts3);
                        w_mac_cmd.mpl   = MPL_W'(w_p8);
                        w_mac_cmd.nb    = NB_W'(8);
                    end
                    OP_B2: begin
                        w_mac_cmd.init  = ACC_W'(w_p1m) <<< 41;
                        w_mac_cmd.mcand = ACC_W'(r_ts) <<< 24;
                        w_mac_cmd.mpl   = MPL_W'(w_p2m);
                        w_mac_cmd.nb    = NB_W'(18);
                    end
                    OP_B3: begin
                        w_mac_cmd.load  = 1'b0;
                        w_mac_cmd.mcand = ACC_W'(r_ts2) <<< 13;
                        w_mac_cmd.mpl   = MPL_W'(w_p3);
                        w_mac_cmd.nb    = NB_W'(8);
                    end
                    OP_B4: begin
                        w_mac_cmd.load  = 1'b0;
                        w_mac_cmd.mcand = ACC_W'(r_ts3);
                        w_mac_cmd.mpl   = MPL_W'(w_p4);
                        w_mac_cmd.nb    = NB_W'(8);
                    end
                    OP_BU: begin
                        w_mac_cmd.mcand = ACC_W'(r_x);
                        w_mac_cmd.mpl   = MPL_W'(r_up);
                        w_mac_cmd.nb    = NB_W'(25);
                    end
                    OP_U2: begin
                        w_mac_cmd.mcand = ACC_W'(r_up);
                        w_mac_cmd.mpl   = MPL_W'(r_up);
                        w_mac_cmd.nb    = NB_W'(25);
                    end
                    OP_C: begin
                        w_mac_cmd.init  = ACC_W'(w_p9) <<< 8;
                        w_mac_cmd.mcand = ACC_W'(r_ts);
                        w_mac_cmd.mpl   = MPL_W'(w_p10);
                        w_mac_cmd.nb    = NB_W'(8);
                    end
                    OP_CU: begin
                        w_mac_cmd.mcand = ACC_W'(r_u);
                        w_mac_cmd.mpl   = MPL_W'(r_c);
                        w_mac_cmd.nb    = NB_W'(25);
                    end
                    OP_U3: begin
                        w_mac_cmd.mcand = ACC_W'(r_u);
                        w_mac_cmd.mpl   = MPL_W'(r_up);
                        w_mac_cmd.nb    = NB_W'(25);
                    end
                    OP_DU: begin
                        w_mac_cmd.mcand = ACC_W'(r_u);
                        w_mac_cmd.mpl   = MPL_W'(w_p11);
                        w_mac_cmd.nb    = NB_W'(8);
                    end
                    OP_PR: begin
                        w_mac_cmd.mcand = ACC_W'(r_p);
                        w_mac_cmd.mpl   = MPL_W'(r_scale);
                        w_mac_cmd.nb    = NB_W'(25);
                    end
                    OP_K: begin
                        w_mac_cmd.mcand = ACC_W'(r_slope);
                        w_mac_cmd.mpl   = MPL_W'(w_kel);
                        w_mac_cmd.nb    = NB_W'(19);
                    end
                    OP_K1000: begin
                        w_mac_cmd.mcand = w_acc;
                        w_mac_cmd.mpl   = MPL_W'(1000);
                        w_mac_cmd.nb    = NB_W'(11);
                    end
                    OP_ALT: begin
                        w_mac_cmd.mcand = ACC_W'(r_fac);
                        w_mac_cmd.mpl   = w_diff;
                        w_mac_cmd.nb    = NB_W'(26);
                    end
                    default: begin
                        w_mac_cmd.start = 1'b0;
                    end
                endcase
                n_state = ST_RUN;
            end

            ST_RUN: begin
                if (!w_mac_busy) begin
                    // retire the step, then issue the next one, start the divider or finish the sample
                    n_state = ST_ISSUE;
                    case (r_op)
                        OP_DD:  begin n_x = w_acc[51:0]; n_op = OP_T3; end
                        OP_T3:  n_op = OP_T2;
                        OP_T2:  begin n_ts = w_ts_sat; n_op = OP_TS2; end
                        OP_TS2: begin n_ts2 = w_acc[31:0]; n_op = OP_TS3; end
                        OP_TS3: begin n_ts3 = w_acc[47:0]; n_op = OP_A6; end
                        OP_A6:  n_op = OP_A7;
                        OP_A7:  n_op = OP_A8;
                        OP_A8:  begin n_p = 48'(w_acc >>> 23); n_op = OP_B2; end
                        OP_B2:  n_op = OP_B3;
                        OP_B3:  n_op = OP_B4;
                        OP_B4:  begin n_x = 52'(w_acc >>> 21); n_op = OP_BU; end
                        OP_BU:  begin n_p = r_p + 48'(w_acc >>> 24); n_op = OP_U2; end
                        OP_U2:  begin n_u = 38'(w_acc >>> 10); n_op = OP_C; end
                        OP_C:   begin n_c = w_acc[24:0]; n_op = OP_CU; end
                        OP_CU:  begin n_p = r_p + 48'(w_acc >>> 30); n_op = OP_U3; end
                        OP_U3:  begin n_u = 38'(w_acc >>> 24); n_op = OP_DU; end
                        OP_DU:  begin n_p = r_p + 48'(w_acc >>> 15); n_op = OP_PR; end
                        OP_PR: begin
                            n_pr = w_pr_sat;
                            n_op = r_cap ? OP_K : OP_ALT;
                        end
                        OP_K:   n_op = OP_K1000;
                        OP_K1000: begin
                            // capture ground; a quotient of 2^32 or more saturates
                            n_gp = r_pr;
                            n_op = OP_ALT;
                            if (r_pr == '0) begin
                                n_fac = '0;
                            end else if (w_acc[63:32] >= w_den) begin
                                n_fac = '1;
                            end else begin
                                w_div_cmd.start = 1'b1;
                                n_op    = OP_K1000;
                                n_state = ST_DIV;
                            end
                        end
                        OP_ALT: begin
                            if (w_out_free) begin
                                n_ov     = 1'b1;
                                n_o_temp = r_ts;
                                n_o_pr   = r_pr;
                                n_o_alt  = w_alt_sat;
                                n_o_cap  = r_cap;
                                n_state  = ST_IDLE;
                            end else begin
                                n_state = ST_RUN;
                            end
                        end
                        default: n_state = ST_IDLE;
                    endcase
                end
            end

            ST_DIV: begin
                if (!w_div_busy) begin
                    n_fac   = w_quot;
                    n_op    = OP_ALT;
                    n_state = ST_ISSUE;
                end
            end

            default: n_state = ST_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state       <= ST_IDLE;
            r_op          <= OP_DD;
            r_gv          <= 1'b0;
            r_gp          <= '0;
            r_fac         <= '0;
            r_cap         <= 1'b0;
            r_ov          <= 1'b0;
            r_temp_coeffs <= '0;
            r_plow        <= '0;
            r_pmid        <= '0;
            r_phigh       <= '0;
            r_scale       <= 24'd65536;
            r_slope       <= '0;
        end else begin
            r_state <= n_state;
            r_op    <= n_op;
            r_gv    <= n_gv;
            r_gp    <= n_gp;
            r_fac   <= n_fac;
            r_cap   <= n_cap;
            r_ov    <= n_ov;
            if (i_cfg_we) begin
                case (i_cfg_idx)
                    CFG_TEMP:  r_temp_coeffs <= i_cfg_data[39:0];
                    CFG_PLOW:  r_plow        <= i_cfg_data[47:0];
                    CFG_PMID:  r_pmid        <= i_cfg_data[47:0];
                    CFG_PHIGH: r_phigh       <= i_cfg_data[31:0];
                    CFG_SCALE: r_scale       <= i_cfg_data[23:0];
                    CFG_SLOPE: r_slope       <= i_cfg_data[31:0];
                    default: ;
                endcase
            end
        end
        r_up     <= n_up;
        r_d      <= n_d;
        r_x      <= n_x;
        r_ts     <= n_ts;
        r_ts2    <= n_ts2;
        r_ts3    <= n_ts3;
        r_p      <= n_p;
        r_u      <= n_u;
        r_c      <= n_c;
        r_pr     <= n_pr;
        r_o_temp <= n_o_temp;
        r_o_pr   <= n_o_pr;
        r_o_alt  <= n_o_alt;
        r_o_cap  <= n_o_cap;
    end

    bcalt_mac u_mac (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_cmd   (w_mac_cmd),
        .o_busy  (w_mac_busy),
        .o_acc   (w_acc)
    );

    bcalt_div u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_cmd   (w_div_cmd),
        .o_busy  (w_div_busy),
        .o_quot  (w_quot)
    );

    assign o_result.valid           = r_ov;
    assign o_result.temperature     = r_o_temp;
    assign o_result.pressure        = r_o_pr;
    assign o_result.altitude        = r_o_alt;
    assign o_result.ground_captured = r_o_cap;

`ifndef SYNTHESIS
    a_mac_idle_on_start: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_mac_cmd.start |-> !w_mac_busy)
        else $error("serial unit started while busy");

    a_div_only_on_capture: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_state == ST_DIV |-> (r_op == OP_K1000 && r_cap))
        else $error("divider running outside a ground capture");

    a_capture_zero_alt: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_ov && r_o_cap) |-> (r_o_alt == '0))
        else $error("capturing sample with nonzero altitude");

    a_ready_only_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_in_xfer |=> (r_state == ST_ISSUE && r_op == OP_DD))
        else $error("sample transfer did not start the sequence");
`endif
endmodule

/* sv/bcalt_mac.sv */
`timescale 1ns / 1ps

// Bit-serial signed multiply-accumulate: one multiplier bit per cycle,
// the top counted bit carries negative weight.
module bcalt_mac (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  bcalt_pkg::t_mac_cmd                 i_cmd,
    output logic                                o_busy,
    output logic signed [bcalt_pkg::ACC_W-1:0]  o_acc
);
    import bcalt_pkg::*;

    logic signed [ACC_W-1:0] r_acc, n_acc;
    logic signed [ACC_W-1:0] r_mcand, n_mcand;
    logic signed [MPL_W-1:0] r_mpl, n_mpl;
    logic [NB_W-1:0]         r_cnt, n_cnt;
    logic signed [ACC_W-1:0] w_add;
    logic signed [ACC_W-1:0] w_init;
    logic signed [ACC_W-1:0] w_mcand;

    assign w_init  = i_cmd.init;
    assign w_mcand = i_cmd.mcand;
    assign w_add   = r_mpl[0] ? ((r_cnt == NB_W'(1)) ? -r_mcand : r_mcand) : '0;

    always_comb begin
        n_acc   = r_acc;
        n_mcand = r_mcand;
        n_mpl   = r_mpl;
        n_cnt   = r_cnt;
        if (i_cmd.start) begin
            n_mcand = w_mcand;
            n_mpl   = i_cmd.mpl;
            n_cnt   = i_cmd.nb;
            if (i_cmd.load) begin
                n_acc = w_init;
            end
        end else if (r_cnt != '0) begin
            n_acc   = r_acc + w_add;
            n_mcand = r_mcand <<< 1;
            n_mpl   = r_mpl >>> 1;
            n_cnt   = r_cnt - NB_W'(1);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cnt <= '0;
        end else begin
            r_cnt <= n_cnt;
        end
        r_acc   <= n_acc;
        r_mcand <= n_mcand;
        r_mpl   <= n_mpl;
    end

    assign o_busy = (r_cnt != '0);
    assign o_acc  = r_acc;
endmodule

/* sv/bcalt_div.sv */
`timescale 1ns / 1ps

// Restoring divider, one quotient bit per cycle. Expects rem < divisor.
module bcalt_div (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  bcalt_pkg::t_div_cmd            i_cmd,
    output logic                           o_busy,
    output logic [bcalt_pkg::DIV_W-1:0]    o_quot
);
    import bcalt_pkg::*;

    logic [DIV_W-1:0]     r_rem, n_rem;
    logic [DIV_W-1:0]     r_lo, n_lo;
    logic [DIV_W-1:0]     r_q, n_q;
    logic [DIV_W-1:0]     r_d, n_d;
    logic [DIV_CNT_W-1:0] r_cnt, n_cnt;
    logic [DIV_W:0]       w_t;
    logic [DIV_W:0]       w_sub;
    logic                 w_ge;

    assign w_t   = {r_rem, r_lo[DIV_W-1]};
    assign w_sub = w_t - {1'b0, r_d};
    assign w_ge  = (w_t >= {1'b0, r_d});

    always_comb begin
        n_rem = r_rem;
        n_lo  = r_lo;
        n_q   = r_q;
        n_d   = r_d;
        n_cnt = r_cnt;
        if (i_cmd.start) begin
            n_rem = i_cmd.rem;
            n_lo  = i_cmd.lo;
            n_d   = i_cmd.divisor;
            n_cnt = DIV_CNT_W'(DIV_W);
        end else if (r_cnt != '0) begin
            n_rem = w_ge ? w_sub[DIV_W-1:0] : w_t[DIV_W-1:0];
            n_lo  = r_lo << 1;
            n_q   = {r_q[DIV_W-2:0], w_ge};
            n_cnt = r_cnt - DIV_CNT_W'(1);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cnt <= '0;
        end else begin
            r_cnt <= n_cnt;
        end
        r_rem <= n_rem;
        r_lo  <= n_lo;
        r_q   <= n_q;
        r_d   <= n_d;
    end

    assign o_busy = (r_cnt != '0);
    assign o_quot = r_q;
endmodule

/* tb/sv/tb_baro_compensate_altitude.sv */
`timescale 1ns / 1ps

module tb_baro_compensate_altitude;
    import bcalt_pkg::*;

    localparam int WATCHDOG_LIMIT = 20000;
    localparam int DRAIN_CYCLES   = 600;
    localparam int HOLD_CYCLES    = 3000;
    localparam int HOLD_AFTER     = 100;
    localparam logic [CFG_IDX_W-1:0] CFG_UNUSED_A = 3'd6;
    localparam logic [CFG_IDX_W-1:0] CFG_UNUSED_B = 3'd7;
    localparam logic signed [127:0] ONE = 1;

    typedef struct {
        logic [RAW_W-1:0] raw_p;
        logic [RAW_W-1:0] raw_t;
        logic             restart;
    } t_sample;

    typedef struct {
        logic signed [TEMP_W-1:0] temp;
        logic [PRESS_W-1:0]       press;
        logic signed [ALT_W-1:0]  alt;
        logic                     captured;
    } t_comp;

    logic i_clk = 1'b0;
    logic i_rst_n = 1'b0;
    logic i_cfg_we = 1'b0;
    logic [CFG_IDX_W-1:0]  i_cfg_idx = '0;
    logic [CFG_DATA_W-1:0] i_cfg_data = '0;

    bcalt_in_if  smp ();
    bcalt_out_if res ();

    baro_compensate_altitude dut (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_sample   (smp.sink),
        .o_result   (res.source),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_idx  (i_cfg_idx),
        .i_cfg_data (i_cfg_data)
    );

    // Toggle the clock every half period (20 ns period).
    always #10 i_clk = ~i_clk;

    // Shadow copy of the configuration and of the ground reference.
    logic [39:0] sh_temp  = '0;
    logic [47:0] sh_plow  = '0;
    logic [47:0] sh_pmid  = '0;
    logic [31:0] sh_phigh = '0;
    logic [23:0] sh_scale = 24'd65536;
    logic [31:0] sh_slope = '0;
    logic [23:0] gnd_press = '0;
    logic [31:0] gnd_mm_per_unit = '0;
    logic        gnd_valid = 1'b0;

    t_sample sample_q[$];
    t_comp   comp_q[$];

    int  errors = 0;
    int  n_results = 0;
    int  idle_cycles = 0;
    int  snd_gap = 0;
    int  rcv_gap = 0;
    int  hold_cnt = 0;
    bit  hold_done = 0;
    bit  took = 0;
    bit  got = 0;
    bit  no_idle = 0;

    function automatic logic signed [127:0] clamp(logic signed [127:0] v,
                                                  logic signed [127:0] lo,
                                                  logic signed [127:0] hi);
        return (v < lo) ? lo : ((v > hi) ? hi : v);
    endfunction

    // Pick a gap length: mostly none or short, now and then long.
    function automatic int pick_gap();
        int r;
        r = $urandom_range(0, 99);
        if (no_idle || r < 60) return 0;
        if (r < 95) return $urandom_range(1, 4);
        return $urandom_range(20, 120);
    endfunction

    // Compensate one sample and advance the ground reference.
    function automatic t_comp compensate(t_sample s);
        logic signed [127:0] up, ut, d, n, ts, ts2, ts3, a, b, bu, u2, c, cu, u3, du;
        logic signed [127:0] p16, pr, f, diff, alt;
        logic signed [127:0] t1, t2, t3, p1, p2, p3, p4, p5, p6, p7, p8, p9, p10, p11;
        t_comp r;
        up = s.raw_p;
        ut = s.raw_t;
        t1 = sh_temp[15:0];
        t2 = sh_temp[31:16];
        t3 = $signed(sh_temp[39:32]);
        p1 = $signed(sh_plow[15:0]);
        p2 = $signed(sh_plow[31:16]);
        p3 = $signed(sh_plow[39:32]);
        p4 = $signed(sh_plow[47:40]);
        p5 = sh_pmid[15:0];
        p6 = sh_pmid[31:16];
        p7 = $signed(sh_pmid[39:32]);
        p8 = $signed(sh_pmid[47:40]);
        p9 = $signed(sh_phigh[15:0]);
        p10 = $signed(sh_phigh[23:16]);
        p11 = $signed(sh_phigh[31:24]);
        if (s.restart) gnd_valid = 1'b0;

        d = ut - t1 * 256;
        n = d * t2 * 262144 + d * d * t3;
        ts = clamp((n + (ONE <<< 39)) >>> 40, -32768, 32767);
        ts2 = ts * ts;
        ts3 = ts2 * ts;

        a = (p5 * (ONE <<< 42) + p6 * ts * (ONE <<< 25) + p7 * ts2 * 32768
             + p8 * ts3) >>> 23;
        b = ((p1 - 16384) * (ONE <<< 41) + (p2 - 16384) * ts * (ONE <<< 24)
             + p3 * ts2 * 8192 + p4 * ts3) >>> 21;
        bu = (b * up) >>> 24;
        u2 = (up * up) >>> 10;
        c = p9 * 256 + p10 * ts;
        cu = (c * u2) >>> 30;
        u3 = (u2 * up) >>> 24;
        du = (p11 * u3) >>> 15;
        p16 = a + bu + cu + du;
        pr = clamp((p16 * $signed({1'b0, sh_scale}) + (ONE <<< 25)) >>> 26, 0, 16777215);

        r.captured = 1'b0;
        if (!gnd_valid) begin
            gnd_press = pr[23:0];
            if (gnd_press == 0) begin
                gnd_mm_per_unit = '0;
            end else begin
                f = ($signed({1'b0, sh_slope}) * (ts + 69926) * 1000)
                    / ($signed({1'b0, gnd_press}) * 256);
                gnd_mm_per_unit = 32'(clamp(f, 0, 64'hFFFF_FFFF));
            end
            gnd_valid = 1'b1;
            r.captured = 1'b1;
        end
        diff = $signed({1'b0, gnd_press}) - pr;
        alt = clamp((diff * $signed({1'b0, gnd_mm_per_unit}) + 32768) >>> 16,
                    -8388608, 8388607);
        r.temp = ts[15:0];
        r.press = pr[23:0];
        r.alt = alt[23:0];
        return r;
    endfunction

    // Sender: predict on each input transfer, then drive at the falling edge.
    always @(posedge i_clk) begin
        took = 0;
        if (i_rst_n && smp.valid && smp.ready) begin
            comp_q.push_back(compensate(sample_q.pop_front()));
            took = 1;
        end
    end

    always @(negedge i_clk) begin
        if (!i_rst_n) begin
            smp.valid <= 1'b0;
        end else if (!smp.valid || took) begin
            if (snd_gap > 0) begin
                snd_gap--;
                smp.valid <= 1'b0;
            end else if (sample_q.size() > 0) begin
                smp.raw_pressure    <= sample_q[0].raw_p;
                smp.raw_temperature <= sample_q[0].raw_t;
                smp.restart_ground  <= sample_q[0].restart;
                smp.valid <= 1'b1;
                snd_gap = pick_gap();
            end else begin
                smp.valid <= 1'b0;
            end
        end
    end

    // Receiver: check each result transfer against the oldest expectation.
    always @(posedge i_clk) begin
        t_comp e;
        got = 0;
        if (i_rst_n && res.valid && res.ready) begin
            got = 1;
            n_results++;
            if (comp_q.size() == 0) begin
                errors++;
                $display("%0t: unexpected result t=%0d p=%0d a=%0d g=%0b", $realtime,
                         res.temperature, res.pressure, res.altitude, res.ground_captured);
            end else begin
                e = comp_q.pop_front();
                if (res.temperature !== e.temp) begin
                    errors++;
                    $display("%0t: temperature expected %0d actual %0d", $realtime,
                             e.temp, res.temperature);
                end
                if (res.pressure !== e.press) begin
                    errors++;
                    $display("%0t: pressure expected %0d actual %0d", $realtime,
                             e.press, res.pressure);
                end
                if (res.altitude !== e.alt) begin
                    errors++;
                    $display("%0t: altitude expected %0d actual %0d", $realtime,
                             e.alt, res.altitude);
                end
                if (res.ground_captured !== e.captured) begin
                    errors++;
                    $display("%0t: ground_captured expected %0b actual %0b", $realtime,
                             e.captured, res.ground_captured);
                end
            end
        end
    end

    // Drive ready; once, hold it low for a long stretch so the block backs up.
    always @(negedge i_clk) begin
        if (hold_cnt > 0) begin
            hold_cnt--;
            res.ready <= 1'b0;
        end else if (!hold_done && n_results >= HOLD_AFTER) begin
            hold_done = 1;
            hold_cnt = HOLD_CYCLES;
            res.ready <= 1'b0;
        end else if (rcv_gap > 0) begin
            rcv_gap--;
            res.ready <= 1'b0;
        end else begin
            res.ready <= 1'b1;
            if (got) rcv_gap = pick_gap();
        end
    end

    // Watchdog: count cycles with no transfer on either channel and no register write.
    always @(posedge i_clk) begin
        if ((smp.valid && smp.ready) || (res.valid && res.ready) || i_cfg_we)
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles >= WATCHDOG_LIMIT) begin
            $display("%0t: watchdog expired", $realtime);
            $display("RESULT: ERROR");
            $finish;
        end
    end

    // Write one register while the block is idle; mirror it in the shadow copy.
    task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] data);
        @(negedge i_clk);
        i_cfg_we <= 1'b1;
        i_cfg_idx <= idx;
        i_cfg_data <= data;
        @(posedge i_clk);
        case (idx)
            CFG_TEMP:  sh_temp  = data[39:0];
            CFG_PLOW:  sh_plow  = data[47:0];
            CFG_PMID:  sh_pmid  = data[47:0];
            CFG_PHIGH: sh_phigh = data[31:0];
            CFG_SCALE: sh_scale = data[23:0];
            CFG_SLOPE: sh_slope = data[31:0];
            default: ;
        endcase
        @(negedge i_clk);
        i_cfg_we <= 1'b0;
    endtask

    task automatic write_all(logic [39:0] t, logic [47:0] lo, logic [47:0] mid,
                             logic [31:0] hi, logic [23:0] sc, logic [31:0] sl);
        write_reg(CFG_TEMP, t);
        write_reg(CFG_PLOW, lo);
        write_reg(CFG_PMID, mid);
        write_reg(CFG_PHIGH, hi);
        write_reg(CFG_SCALE, sc);
        write_reg(CFG_SLOPE, sl);
    endtask

    // Hold the sender until every expected result has come, then settle.
    task automatic drain();
        wait (sample_q.size() == 0 && comp_q.size() == 0);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
    endtask

    task automatic add(logic [23:0] p, logic [23:0] t, logic rg);
        t_sample s;
        s.raw_p = p;
        s.raw_t = t;
        s.restart = rg;
        sample_q.push_back(s);
    endtask

    // Mostly coherent runs: restart, then small steps around a base pair.
    task automatic add_random(int count);
        int i, run;
        logic [23:0] bp, bt;
        i = 0;
        while (i < count) begin
            if ($urandom_range(0, 9) < 2) begin
                add(24'($urandom), 24'($urandom), 1'($urandom_range(0, 1)));
                i++;
            end else begin
                bp = 24'($urandom);
                bt = 24'($urandom);
                run = $urandom_range(5, 25);
                add(bp, bt, 1'b1);
                i++;
                repeat (run) begin
                    add(24'(bp + $urandom_range(0, 8191) - 4096),
                        24'(bt + $urandom_range(0, 511) - 256),
                        $urandom_range(0, 49) == 0);
                    i++;
                end
            end
        end
    endtask

    // Coefficients roughly in the range real parts carry.
    task automatic write_plausible();
        write_all({8'($urandom_range(0, 15) - 8), 16'($urandom_range(17000, 19000)),
                   16'($urandom_range(26000, 28000))},
                  {8'($urandom_range(0, 7)), 8'($urandom_range(0, 40)),
                   16'($urandom_range(0, 3000)), 16'($urandom_range(0, 3000))},
                  {8'($urandom_range(0, 7) - 4), 8'($urandom_range(0, 15)),
                   16'($urandom_range(20000, 30000)), 16'($urandom_range(20000, 30000))},
                  {8'($urandom_range(0, 31) - 16), 8'($urandom_range(0, 15)),
                   16'($urandom_range(0, 4000))},
                  24'($urandom_range(32768, 131072)), $urandom_range(0, 2000000));
    endtask

    initial begin
        smp.valid = 1'b0;
        smp.raw_pressure = '0;
        smp.raw_temperature = '0;
        smp.restart_ground = 1'b0;
        res.ready = 1'b0;
        repeat (6) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        // Reset defaults: all-zero coefficients, zero ground pressure.
        add(24'h000000, 24'h000000, 1'b0);
        add(24'hFFFFFF, 24'hFFFFFF, 1'b0);
        add(24'h800000, 24'h800000, 1'b1);
        drain();

        // Directed: field extremes, capture, restart, zero ground.
        write_plausible();
        add(24'h000000, 24'h000000, 1'b1);
        add(24'hFFFFFF, 24'hFFFFFF, 1'b0);
        add(24'h000000, 24'hFFFFFF, 1'b0);
        add(24'hFFFFFF, 24'h000000, 1'b0);
        add(24'h6B0000, 24'h800000, 1'b1);
        add(24'h6B1000, 24'h800000, 1'b0);
        add(24'h6AF000, 24'h800100, 1'b0);
        add(24'hAAAAAA, 24'h555555, 1'b0);
        add(24'h555555, 24'hAAAAAA, 1'b1);
        add(24'h555600, 24'hAAAAAA, 1'b0);
        add(24'h7FFFFF, 24'h7FFFFF, 1'b1);
        add(24'h800000, 24'h800000, 1'b0);
        drain();
        write_reg(CFG_UNUSED_A, {CFG_DATA_W{1'b1}});
        write_reg(CFG_UNUSED_B, {CFG_DATA_W{1'b1}});
        add(24'h6B0000, 24'h800000, 1'b1);
        add(24'h6A0000, 24'h800000, 1'b0);
        drain();

        // All ones, then all zeros with maximum scale and slope.
        write_all('1, '1, '1, '1, '1, '1);
        add_random(60);
        drain();
        write_all('0, '0, '0, '0, '1, '1);
        add_random(40);
        drain();
        write_plausible();
        write_reg(CFG_SCALE, '0);
        add_random(40);
        drain();

        // Random settings, plausible and fully random, with and without idling.
        for (int ph = 0; ph < 10; ph++) begin
            no_idle = (ph % 4 == 3);
            if (ph % 3 == 2)
                write_all(40'({$urandom, $urandom}), 48'({$urandom, $urandom}),
                          48'({$urandom, $urandom}), $urandom, 24'($urandom), $urandom);
            else
                write_plausible();
            add_random(130);
            drain();
        end

        if (errors == 0) begin
            $display("RESULT: OK");
        end else begin
            $display("RESULT: ERROR");
        end
        $finish;
    end

endmodule
